// ===== sv/sfg_pkg.sv =====
`timescale 1ns / 1ps
// sfg_pkg: shared types, operation codes and frame constants of the frame generator
// depends on nothing; imported by every module of the block

package sfg_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int BITS_PER_CH  = 11;
    localparam int CH_W         = 4;
    localparam int DATA_BYTES   = 22;
    localparam int DATA_BITS    = DATA_BYTES * 8;
    localparam int FRAME_LEN    = 25;
    localparam int CNT_W        = 5;

    localparam logic [4:0]  FLAG_BYTE  = 5'd22;
    localparam logic [7:0]  START_BYTE = 8'h0F;
    localparam logic [7:0]  END_BYTE   = 8'h00;
    localparam logic [15:0] PW_MIN     = 16'd880;
    localparam logic [15:0] PW_MAX     = 16'd2160;
    localparam logic [15:0] RECIP_5    = 16'd52429;
    localparam logic [7:0]  PERIOD_RST = 8'd14;

    localparam logic [2:0] OP_RAW   = 3'd0;
    localparam logic [2:0] OP_PW    = 3'd1;
    localparam logic [2:0] OP_FLAGS = 3'd2;
    localparam logic [2:0] OP_SEND  = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;
    localparam logic [2:0] OP_POLL  = 3'd5;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_POLL  = 1'b1;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  channel;
        logic [15:0] value;
        logic [7:0]  flag_mask;
        logic        flag_on;
        logic [2:0]  client;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  frame_byte;
        logic        last;
        logic        sync_ready;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic             raw_wr;
        logic             flag_wr;
        logic             tick;
        logic             poll;
        logic             pw_load;
        logic             pw_mul;
        logic             pw_div;
        logic             pw_wr;
        logic             emit;
        logic [CNT_W-1:0] byte_sel;
        logic             send_done;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic chan_ok;
    } dp_sts_t;

endpackage

// ===== sv/sfg_datapath.sv =====
`timescale 1ns / 1ps
// sfg_datapath: frame store, pulse width mapping, sync timer and result register
// depends on sfg_pkg; driven by sfg_ctrl commands

module sfg_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  sfg_pkg::in_item_t  item,
    input  sfg_pkg::dp_cmd_t   cmd,
    output sfg_pkg::dp_sts_t   sts,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    output sfg_pkg::out_item_t result,
    output logic               result_strobe
);
    import sfg_pkg::*;

    logic [DATA_BITS-1:0]   chan_bits_reg, chan_bits_next;
    logic [7:0]             flag_reg;
    logic [7:0]             sync_reg;
    logic [7:0]             elapsed_reg;
    logic [7:0]             period_reg;
    logic [10:0]            diff_reg;
    logic [21:0]            prod_reg;
    logic [10:0]            quot_reg;
    logic [CH_W-1:0]        chidx_reg;
    out_item_t              res_reg, res_next;
    logic                   strobe_reg;

    logic [15:0]            clamped;
    logic [CH_W-1:0]        ch_idx;
    logic                   wr_en;
    logic [CH_W-1:0]        wr_idx;
    logic [10:0]            wr_data;
    logic [CNT_W-1:0]       store_sel;
    logic [7:0]             store_byte;
    logic [7:0]             frame_byte;
    logic [7:0]             elapsed_inc;
    logic [30:0]            recip_prod;
    logic [7:0]             client_mask;

    assign sts.chan_ok = (item.channel >= 8'd1) && (item.channel <= 8'(NUM_CHANNELS));
    assign ch_idx      = CH_W'(item.channel - 8'd1);

    always_comb
    begin
        if (item.value < PW_MIN)
        begin
            clamped = PW_MIN;
        end
        else if (item.value > PW_MAX)
        begin
            clamped = PW_MAX;
        end
        else
        begin
            clamped = item.value;
        end
    end

    // divide by 1280: drop 8 bits, then multiply by the reciprocal of 5
    assign recip_prod = 31'(prod_reg[21:8]) * 31'(RECIP_5);

    // channel field write
    assign wr_en   = cmd.raw_wr | cmd.pw_wr;
    assign wr_idx  = cmd.pw_wr ? chidx_reg : ch_idx;
    assign wr_data = cmd.pw_wr ? quot_reg : item.value[10:0];

    always_comb
    begin
        chan_bits_next = chan_bits_reg;
        if (wr_en)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                if (wr_idx == CH_W'(c))
                begin
                    chan_bits_next[c*BITS_PER_CH +: BITS_PER_CH] = wr_data;
                end
            end
        end
    end

    // frame byte selection: start byte, store bytes, end byte
    assign store_sel = cmd.byte_sel - 5'd1;

    always_comb
    begin
        if (store_sel == FLAG_BYTE)
        begin
            store_byte = flag_reg;
        end
        else
        begin
            store_byte = chan_bits_reg[{store_sel, 3'b000} +: 8];
        end
    end

    always_comb
    begin
        if (cmd.byte_sel == CNT_W'(0))
        begin
            frame_byte = START_BYTE;
        end
        else if (cmd.byte_sel == CNT_W'(FRAME_LEN - 1))
        begin
            frame_byte = END_BYTE;
        end
        else
        begin
            frame_byte = store_byte;
        end
    end

    assign elapsed_inc = elapsed_reg + 8'd1;
    assign client_mask = 8'd1 << item.client;

    always_comb
    begin
        res_next = res_reg;
        if (cmd.emit)
        begin
            res_next.kind       = KIND_FRAME;
            res_next.frame_byte = frame_byte;
            res_next.last       = cmd.send_done;
            res_next.sync_ready = 1'b0;
        end
        else if (cmd.poll)
        begin
            res_next.kind       = KIND_POLL;
            res_next.frame_byte = 8'h00;
            res_next.last       = 1'b1;
            res_next.sync_ready = |(sync_reg & client_mask);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_bits_reg <= '0;
            flag_reg      <= 8'h00;
            sync_reg      <= 8'h00;
            elapsed_reg   <= 8'h00;
            period_reg    <= PERIOD_RST;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            chan_bits_reg <= chan_bits_next;
            strobe_reg    <= cmd.emit | cmd.poll;
            if (cfg_we)
            begin
                period_reg <= cfg_data;
            end
            if (cmd.flag_wr)
            begin
                flag_reg <= item.flag_on ? (flag_reg | item.flag_mask)
                                         : (flag_reg & ~item.flag_mask);
            end
            if (cmd.send_done)
            begin
                sync_reg    <= 8'h00;
                elapsed_reg <= 8'h00;
            end
            else if (cmd.tick)
            begin
                elapsed_reg <= elapsed_inc;
                if ((sync_reg == 8'h00) && (elapsed_inc >= period_reg))
                begin
                    sync_reg <= 8'hFF;
                end
            end
            else if (cmd.poll)
            begin
                sync_reg <= sync_reg & ~client_mask;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.pw_load)
        begin
            diff_reg  <= 11'(clamped - PW_MIN);
            chidx_reg <= ch_idx;
        end
        if (cmd.pw_mul)
        begin
            prod_reg <= {diff_reg, 11'd0} - 22'(diff_reg);
        end
        if (cmd.pw_div)
        begin
            quot_reg <= recip_prod[28:18];
        end
    end

    assign result        = res_reg;
    assign result_strobe = strobe_reg;

endmodule

// ===== sv/sfg_ctrl.sv =====
`timescale 1ns / 1ps
// sfg_ctrl: request decode and sequencing of pulse width mapping and frame send
// depends on sfg_pkg; commands sfg_datapath

module sfg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2:0]       operation,
    input  sfg_pkg::dp_sts_t sts,
    output sfg_pkg::dp_cmd_t cmd,
    output logic             busy
);
    import sfg_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PW_MUL = 3'd1;
    localparam logic [2:0] S_PW_DIV = 3'd2;
    localparam logic [2:0] S_PW_WR  = 3'd3;
    localparam logic [2:0] S_SEND   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        OP_RAW:   cmd.raw_wr = sts.chan_ok;
                        OP_PW:
                        begin
                            cmd.pw_load = 1'b1;
                            if (sts.chan_ok)
                            begin
                                state_next = S_PW_MUL;
                            end
                        end
                        OP_FLAGS: cmd.flag_wr = 1'b1;
                        OP_SEND:
                        begin
                            state_next = S_SEND;
                            cnt_next   = '0;
                        end
                        OP_TICK:  cmd.tick = 1'b1;
                        OP_POLL:  cmd.poll = 1'b1;
                        default:  ;
                    endcase
                end
            end
            S_PW_MUL:
            begin
                cmd.pw_mul = 1'b1;
                state_next = S_PW_DIV;
            end
            S_PW_DIV:
            begin
                cmd.pw_div = 1'b1;
                state_next = S_PW_WR;
            end
            S_PW_WR:
            begin
                cmd.pw_wr  = 1'b1;
                state_next = S_IDLE;
            end
            S_SEND:
            begin
                cmd.emit     = 1'b1;
                cmd.byte_sel = cnt_reg;
                if (cnt_reg == CNT_W'(FRAME_LEN - 1))
                begin
                    cmd.send_done = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== sv/sbus_frame_generator_core.sv =====
`timescale 1ns / 1ps
// sbus_frame_generator_core: top level of the frame generator
// depends on sfg_pkg, sfg_ctrl and sfg_datapath
//
// latency: a poll answer is on the result ports in the cycle after the request
// send: 25 bytes back to back, the first after the state register and the result register;
//   busy stays high while the bytes are emitted, so no new request is taken during a send
// pulse width request: multiply, reciprocal divide and field write states in turn; others need none
// reset: frame store and sync state cleared, frame period back to 14 ms
// results cannot be stalled; each is shown for one cycle with result_strobe

module sbus_frame_generator_core (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  sfg_pkg::in_item_t  item,
    // frame period register
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    // results
    output logic               result_strobe,
    output sfg_pkg::out_item_t result
);
    import sfg_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    cfg_we;

    // the period register is only changed between requests
    assign cfg_ready = ~busy;
    assign cfg_we    = cfg_valid & cfg_ready;

    // state machine: decodes requests and steps the send byte counter
    sfg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    // frame store, pulse width arithmetic, sync timer and result register
    sfg_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

// ===== sv/sfg_checker.sv =====
`timescale 1ns / 1ps
// sfg_checker: port level checks of the frame generator, bound to the top level
// depends on sfg_pkg and sbus_frame_generator_core

module sfg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input sfg_pkg::in_item_t  item,
    input logic               result_strobe,
    input sfg_pkg::out_item_t result
);
    import sfg_pkg::*;

    // poll answer follows its request directly
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.operation == OP_POLL)
        |=> result_strobe && (result.kind == KIND_POLL) && result.last)
    else $error("poll answer missing");

    // a send holds off requests and shows no result in its first cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.operation == OP_SEND) |=> busy && !result_strobe)
    else $error("send did not start");

    // the end byte is 0x00 and the block is free again when it shows
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (result.kind == KIND_FRAME) && result.last
        |-> !busy && (result.frame_byte == END_BYTE))
    else $error("bad frame end");

    // a frame byte is shown only while a send is in progress or right at its end
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (result.kind == KIND_FRAME) && !result.last |-> busy)
    else $error("frame byte outside a send");

    // poll answers carry no frame byte
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (result.kind == KIND_POLL) |-> (result.frame_byte == 8'h00))
    else $error("poll answer carries data");

endmodule

bind sbus_frame_generator_core sfg_checker u_sfg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result)
);
